>>> rtl/core/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared constants and types for the indexed list store: the default
// capacity, the action codes of a request word and the sequencer states.
// ----------------------------------------------------------------------------
package ils_pkg;

	// Default number of entries held by the store.
	localparam int ILS_CAPACITY = 64;

	// Action codes carried in the request word.
	typedef enum logic [2:0] {
		ACT_APPEND    = 3'd0,
		ACT_READ      = 3'd1,
		ACT_OVERWRITE = 3'd2,
		ACT_INSERT    = 3'd3,
		ACT_REMOVE    = 3'd4,
		ACT_SEARCH    = 3'd5,
		ACT_CLEAR     = 3'd6
	} action_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_UP,
		ST_DN,
		ST_SR,
		ST_DRAIN,
		ST_PUT,
		ST_FIN
	} state_t;

endpackage

>>> rtl/core/indexed_list_store_top.sv
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Ordered list of nonzero 32-bit words with append, read, overwrite, insert,
// remove, search and clear, one response word per request word.
// ----------------------------------------------------------------------------
// The block takes one request word at a time and answers each with exactly
// one response word. Read reads one entry; insert in the middle, remove and
// search walk the entry memory one entry per cycle, over at most the current
// length (up to the default capacity of 64 entries). Append, overwrite, clear
// and any rejected request write at most one entry and walk nothing. The
// entry memory has one write port and one read port with registered read
// data. A finished response waits in an output register; the next request
// is taken once the current one has been handed to that register. No
// clearing pass follows reset: only entries below the current length are
// ever read.
module indexed_list_store_top
	import ils_pkg::*;
#(
	parameter int CAPACITY = ILS_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  action,
	input  logic [6:0]  position,
	input  logic [31:0] element,
	// Response channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        status,
	output logic [31:0] data,
	output logic        found,
	output logic [5:0]  found_index,
	output logic [6:0]  length,
	output logic        empty_res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [31:0]   mem_wr_data;
	logic [AW-1:0] mem_rd_addr;
	logic [31:0]   mem_rd_data;

	// Request sequencer and output register.
	ils_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.position    (position),
		.element     (element),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.data        (data),
		.found       (found),
		.found_index (found_index),
		.length      (length),
		.empty_res   (empty_res),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	// Entry memory.
	ils_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule

>>> rtl/core/ils_mem.sv
// ----------------------------------------------------------------------------
// ils_mem
// Entry memory of the list: one write port and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module ils_mem
	import ils_pkg::*;
#(
	parameter int DEPTH = ILS_CAPACITY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data
);

	logic [31:0] mem_q [DEPTH];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> rtl/core/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl
// Request sequencer of the indexed list store. It decodes one request word,
// walks the entry memory one entry per cycle for shifts and searches, keeps
// the entry count and holds the response word in an output register.
// ----------------------------------------------------------------------------
module ils_ctrl
	import ils_pkg::*;
#(
	parameter int CAPACITY = ILS_CAPACITY,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	// Request channel
	input  logic          req_valid,
	output logic          req_stall,
	input  logic [2:0]    action,
	input  logic [6:0]    position,
	input  logic [31:0]   element,
	// Response channel
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output logic          status,
	output logic [31:0]   data,
	output logic          found,
	output logic [5:0]    found_index,
	output logic [6:0]    length,
	output logic          empty_res,
	// Entry memory
	output logic          mem_wr_en,
	output logic [AW-1:0] mem_wr_addr,
	output logic [31:0]   mem_wr_data,
	output logic [AW-1:0] mem_rd_addr,
	input  logic [31:0]   mem_rd_data
);

	localparam int MW = (CW > 7) ? CW : 7;

	state_t         state_q, state_d;
	logic [AW-1:0]  ptr_q, ptr_d;
	logic [2:0]     act_q, act_d;
	logic [AW-1:0]  pos_q, pos_d;
	logic [31:0]    elem_q, elem_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic           err_q, err_d;
	logic [31:0]    data_q, data_d;
	logic           found_q, found_d;
	logic [AW-1:0]  idx_q, idx_d;
	logic           rd_vld_s1, vld_d;
	logic [AW-1:0]  rd_tag_s1, tag_d;
	logic           rd_cap_s1, cap_d;
	logic           out_load;
	logic           rsp_valid_q;
	logic           out_status_q;
	logic [31:0]    out_data_q;
	logic           out_found_q;
	logic [5:0]     out_idx_q;
	logic [6:0]     out_len_q;
	logic           out_empty_q;

	logic [MW-1:0]  pos_w;
	logic [MW-1:0]  cnt_w;
	logic           elem_nz;
	logic           pos_lt;
	logic           pos_eq;
	logic           full;
	logic [AW-1:0]  cnt_idx;
	logic [AW-1:0]  last_idx;
	logic           hit;

	// Request checks against the current entry count.
	assign pos_w    = MW'(position);
	assign cnt_w    = MW'(cnt_q);
	assign elem_nz  = (element != 32'd0);
	assign pos_lt   = (pos_w < cnt_w);
	assign pos_eq   = (pos_w == cnt_w);
	assign full     = (cnt_q == CW'(CAPACITY));
	assign cnt_idx  = AW'(cnt_q);
	assign last_idx = AW'(cnt_q - CW'(1));

	// A search compare that finds the first equal entry.
	assign hit = rd_vld_s1 && !rd_cap_s1 && (act_q == ACT_SEARCH) && !found_q
		&& (mem_rd_data == elem_q);

	assign req_stall   = (state_q != ST_IDLE);
	assign mem_rd_addr = ptr_q;

	// Next state, memory port control and result bookkeeping.
	always_comb begin
		state_d     = state_q;
		ptr_d       = ptr_q;
		act_d       = act_q;
		pos_d       = pos_q;
		elem_d      = elem_q;
		cnt_d       = cnt_q;
		err_d       = err_q;
		data_d      = data_q;
		found_d     = found_q;
		idx_d       = idx_q;
		vld_d       = 1'b0;
		tag_d       = ptr_q;
		cap_d       = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = pos_q;
		mem_wr_data = elem_q;
		out_load    = 1'b0;

		// Read data returning from the previous cycle's read.
		if (rd_vld_s1) begin
			if (rd_cap_s1) begin
				data_d = mem_rd_data;
			end else if (act_q == ACT_SEARCH) begin
				if (hit) begin
					found_d = 1'b1;
					idx_d   = rd_tag_s1;
				end
			end else begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = rd_tag_s1;
				mem_wr_data = mem_rd_data;
			end
		end

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					act_d   = action;
					pos_d   = AW'(position);
					elem_d  = element;
					err_d   = 1'b1;
					data_d  = 32'd0;
					found_d = 1'b0;
					idx_d   = '0;
					state_d = ST_FIN;
					case (action)
						ACT_APPEND: begin
							if (elem_nz && !full) begin
								err_d       = 1'b0;
								mem_wr_en   = 1'b1;
								mem_wr_addr = cnt_idx;
								mem_wr_data = element;
								cnt_d       = cnt_q + CW'(1);
							end
						end
						ACT_READ: begin
							if (pos_lt) begin
								err_d   = 1'b0;
								ptr_d   = AW'(position);
								state_d = ST_RD;
							end
						end
						ACT_OVERWRITE: begin
							if (elem_nz && pos_lt) begin
								err_d       = 1'b0;
								mem_wr_en   = 1'b1;
								mem_wr_addr = AW'(position);
								mem_wr_data = element;
							end else if (elem_nz && pos_eq && !full) begin
								err_d       = 1'b0;
								mem_wr_en   = 1'b1;
								mem_wr_addr = cnt_idx;
								mem_wr_data = element;
								cnt_d       = cnt_q + CW'(1);
							end
						end
						ACT_INSERT: begin
							if (elem_nz && !full && pos_eq) begin
								err_d       = 1'b0;
								mem_wr_en   = 1'b1;
								mem_wr_addr = cnt_idx;
								mem_wr_data = element;
								cnt_d       = cnt_q + CW'(1);
							end else if (elem_nz && !full && pos_lt) begin
								err_d   = 1'b0;
								ptr_d   = last_idx;
								state_d = ST_UP;
							end
						end
						ACT_REMOVE: begin
							if (pos_lt) begin
								err_d   = 1'b0;
								ptr_d   = AW'(position);
								state_d = ST_DN;
							end
						end
						ACT_SEARCH: begin
							if (elem_nz) begin
								err_d = 1'b0;
								ptr_d = '0;
								if (cnt_q != '0) begin
									state_d = ST_SR;
								end
							end
						end
						ACT_CLEAR: begin
							err_d = 1'b0;
							cnt_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			// Single read whose word is returned.
			ST_RD: begin
				vld_d   = 1'b1;
				cap_d   = 1'b1;
				state_d = ST_DRAIN;
			end
			// Shift the tail up, walking from the last entry down to the slot.
			ST_UP: begin
				vld_d = 1'b1;
				tag_d = ptr_q + AW'(1);
				if (ptr_q == pos_q) begin
					state_d = ST_DRAIN;
				end else begin
					ptr_d = ptr_q - AW'(1);
				end
			end
			// Capture the removed word, then shift the tail down.
			ST_DN: begin
				vld_d = 1'b1;
				cap_d = (ptr_q == pos_q);
				tag_d = ptr_q - AW'(1);
				if (ptr_q == last_idx) begin
					state_d = ST_DRAIN;
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			// Scan upward until the first equal entry or the end of the list.
			ST_SR: begin
				vld_d = 1'b1;
				if (hit) begin
					state_d = ST_FIN;
				end else if (ptr_q == last_idx) begin
					state_d = ST_DRAIN;
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			// Last read word is handled above; settle the count.
			ST_DRAIN: begin
				if (act_q == ACT_REMOVE) begin
					cnt_d = cnt_q - CW'(1);
				end
				state_d = (act_q == ACT_INSERT) ? ST_PUT : ST_FIN;
			end
			// Place the inserted word into the opened slot.
			ST_PUT: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = pos_q;
				mem_wr_data = elem_q;
				cnt_d       = cnt_q + CW'(1);
				state_d     = ST_FIN;
			end
			// Hand the response word to the output register once it is free.
			ST_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			rd_vld_s1 <= vld_d;
		end
	end

	// Request fields, walk pointer and staged result.
	always_ff @(posedge clk) begin
		ptr_q     <= ptr_d;
		act_q     <= act_d;
		pos_q     <= pos_d;
		elem_q    <= elem_d;
		err_q     <= err_d;
		data_q    <= data_d;
		found_q   <= found_d;
		idx_q     <= idx_d;
		rd_tag_s1 <= tag_d;
		rd_cap_s1 <= cap_d;
	end

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output word payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= err_q;
			out_data_q   <= data_q;
			out_found_q  <= found_q;
			out_idx_q    <= 6'(idx_q);
			out_len_q    <= 7'(cnt_q);
			out_empty_q  <= (cnt_q == '0);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = out_status_q;
	assign data        = out_data_q;
	assign found       = out_found_q;
	assign found_index = out_idx_q;
	assign length      = out_len_q;
	assign empty_res   = out_empty_q;

endmodule

>>> tb/sv/list_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_scoreboard_pkg
// Tracks the contents of the indexed list store as seen from its ports.
// Each accepted request word updates a private copy of the list and queues
// the response word it must produce, and each response word taken from the
// block is checked field by field against the oldest queued response.
// ----------------------------------------------------------------------------
package list_scoreboard_pkg;

	import ils_pkg::*;

	// One response word, field for field as the block reports it.
	typedef struct packed {
		logic        status;
		logic [31:0] data;
		logic        found;
		logic [5:0]  found_index;
		logic [6:0]  length;
		logic        empty_res;
	} list_response_t;

	localparam int MAX_REPORTED = 10;

	class list_scoreboard;

		logic [31:0]    entries [ILS_CAPACITY];
		int unsigned    count;
		list_response_t expected_q [$];
		int unsigned    failures;

		function new();
			count    = 0;
			failures = 0;
		endfunction

		function int unsigned length_now();
			return count;
		endfunction

		function logic [31:0] entry_at(int unsigned idx);
			return entries[idx];
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Apply one accepted request word to the list and queue its response.
		function void note_request(logic [2:0] act, logic [6:0] pos, logic [31:0] elem);
			list_response_t rsp;
			logic           full;
			int unsigned    i;
			rsp        = '0;
			rsp.status = 1'b1;
			full       = (count >= ILS_CAPACITY);
			case (act)
				ACT_APPEND: begin
					if (elem != 0 && !full) begin
						entries[count] = elem;
						count++;
						rsp.status = 1'b0;
					end
				end
				ACT_READ: begin
					if (pos < count) begin
						rsp.data   = entries[pos];
						rsp.status = 1'b0;
					end
				end
				ACT_OVERWRITE: begin
					// A write one past the last entry grows the list.
					if (elem != 0 && pos < count) begin
						entries[pos] = elem;
						rsp.status   = 1'b0;
					end else if (elem != 0 && pos == count && !full) begin
						entries[count] = elem;
						count++;
						rsp.status = 1'b0;
					end
				end
				ACT_INSERT: begin
					if (elem != 0 && pos <= count && !full) begin
						for (i = count; i > pos; i--)
							entries[i] = entries[i - 1];
						entries[pos] = elem;
						count++;
						rsp.status = 1'b0;
					end
				end
				ACT_REMOVE: begin
					if (pos < count) begin
						rsp.data = entries[pos];
						for (i = pos; i + 1 < count; i++)
							entries[i] = entries[i + 1];
						count--;
						rsp.status = 1'b0;
					end
				end
				ACT_SEARCH: begin
					// The first equal entry wins; a miss is still a success.
					if (elem != 0) begin
						rsp.status = 1'b0;
						for (i = 0; i < count; i++) begin
							if (entries[i] == elem) begin
								rsp.found       = 1'b1;
								rsp.found_index = 6'(i);
								break;
							end
						end
					end
				end
				ACT_CLEAR: begin
					count      = 0;
					rsp.status = 1'b0;
				end
				default: begin
				end
			endcase
			rsp.length    = 7'(count);
			rsp.empty_res = (count == 0);
			expected_q.push_back(rsp);
		endfunction

		// Compare one response word with the oldest queued response.
		function void check_response(list_response_t got);
			list_response_t want;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTED)
					$display("mismatch: response word with no request pending");
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.data !== want.data ||
					got.found !== want.found || got.found_index !== want.found_index ||
					got.length !== want.length || got.empty_res !== want.empty_res) begin
				failures++;
				if (failures <= MAX_REPORTED) begin
					$display("mismatch (expected/actual): status %0d/%0d data %h/%h",
						want.status, got.status, want.data, got.data);
					$display("  found %0d/%0d index %0d/%0d length %0d/%0d empty %0d/%0d",
						want.found, got.found, want.found_index, got.found_index,
						want.length, got.length, want.empty_res, got.empty_res);
				end
			end
		endfunction

	endclass

endpackage

>>> tb/sv/indexed_list_store_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_store_top_test
// Drives request words into the indexed list store and checks every
// response word against a scoreboard that keeps its own copy of the list.
// A directed opening covers the error cases and every action, then random
// phases of growing, shrinking and mixed traffic run under several mixes
// of sender idling and receiver stalling, one with a long receiver hold-off.
// ----------------------------------------------------------------------------
module indexed_list_store_top_test;

	import ils_pkg::*;
	import list_scoreboard_pkg::*;

	localparam logic [2:0]  ACT_UNDEFINED  = 3'd7;
	localparam int          CYCLE_LIMIT    = 1000000;
	localparam int          HOLDOFF_CYCLES = 400;
	localparam int          DRAIN_CYCLES   = 200;
	localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

	// Traffic shapes of the random part.
	typedef enum int {
		MODE_GROW,
		MODE_SHRINK,
		MODE_MIXED
	} traffic_mode_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [2:0]  action;
	logic [6:0]  position;
	logic [31:0] element;
	logic        rsp_valid;
	logic        rsp_stall;
	logic        status;
	logic [31:0] data;
	logic        found;
	logic [5:0]  found_index;
	logic [6:0]  length;
	logic        empty_res;

	list_scoreboard sb;
	int             send_idle_pct;
	int             recv_stall_pct;
	bit             holdoff_pending;
	int             cycle_count;
	traffic_mode_t  mode;
	int             mode_left;

	indexed_list_store_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.position    (position),
		.element     (element),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.data        (data),
		.found       (found),
		.found_index (found_index),
		.length      (length),
		.empty_res   (empty_res)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one request word, with random idle cycles before it, and wait
	// until the block takes it.
	task automatic send_request(input logic [2:0] act, input logic [6:0] pos,
			input logic [31:0] elem);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		action    <= act;
		position  <= pos;
		element   <= elem;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(act, pos, elem);
		@(negedge clk);
	endtask

	// Random request words, mostly well-formed for the current list length,
	// with occasional out-of-range positions, zero elements and bad actions.
	task automatic send_random(input int n);
		logic [2:0]  act;
		logic [6:0]  pos;
		logic [31:0] elem;
		int unsigned len;
		int unsigned top;
		int unsigned r;
		repeat (n) begin
			if (mode_left == 0) begin
				mode      = traffic_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(30, 120);
			end
			mode_left--;
			len = sb.length_now();
			r   = $urandom_range(0, 99);
			case (mode)
				MODE_GROW:
					act = r < 35 ? ACT_APPEND : r < 55 ? ACT_INSERT :
						r < 65 ? ACT_OVERWRITE : r < 75 ? ACT_READ :
						r < 87 ? ACT_SEARCH : r < 95 ? ACT_REMOVE :
						r < 99 ? ACT_UNDEFINED : ACT_CLEAR;
				MODE_SHRINK:
					act = r < 40 ? ACT_REMOVE : r < 55 ? ACT_READ :
						r < 70 ? ACT_SEARCH : r < 80 ? ACT_OVERWRITE :
						r < 87 ? ACT_INSERT : r < 95 ? ACT_APPEND :
						r < 98 ? ACT_UNDEFINED : ACT_CLEAR;
				default:
					act = r < 18 ? ACT_APPEND : r < 33 ? ACT_READ :
						r < 45 ? ACT_OVERWRITE : r < 60 ? ACT_INSERT :
						r < 75 ? ACT_REMOVE : r < 92 ? ACT_SEARCH :
						r < 96 ? ACT_CLEAR : ACT_UNDEFINED;
			endcase

			// Insert and overwrite may target one past the last entry.
			top = (act == ACT_INSERT || act == ACT_OVERWRITE) ? len :
				(len == 0 ? 0 : len - 1);
			r = $urandom_range(0, 99);
			if (r < 10)
				pos = '0;
			else if (r < 20)
				pos = 7'(top);
			else if (r < 80)
				pos = 7'($urandom_range(0, top));
			else if (r < 90)
				pos = 7'(len + 1);
			else
				pos = 7'($urandom_range(0, 127));

			// Reuse stored words often so that searches hit and duplicates exist.
			r = $urandom_range(0, 99);
			if (r < 4)
				elem = '0;
			else if (r < 34 && len > 0)
				elem = sb.entry_at($urandom_range(0, len - 1));
			else if (r < 44)
				elem = $urandom_range(1, 6);
			else if (r < 50)
				elem = ALL_ONES;
			else
				elem = $urandom;
			send_request(act, pos, elem);
		end
	endtask

	// Receiver: random stalls, and one long hold-off when asked for.
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_pending) begin
				holdoff_pending = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
			end
			rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Take each accepted response word to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response('{status, data, found, found_index, length, empty_res});
	end

	// Watchdog on the whole run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Main sequence.
	initial begin
		sb              = new();
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		holdoff_pending = 1'b0;
		mode            = MODE_GROW;
		mode_left       = 0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		action    <= ACT_APPEND;
		position  <= '0;
		element   <= '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening: errors on an empty list, every action, the ends.
		send_request(ACT_APPEND,    7'd0,   32'd0);
		send_request(ACT_READ,      7'd0,   ALL_ONES);
		send_request(ACT_REMOVE,    7'd0,   32'd0);
		send_request(ACT_SEARCH,    7'd0,   ALL_ONES);
		send_request(ACT_SEARCH,    7'd5,   32'd0);
		send_request(ACT_APPEND,    7'd127, ALL_ONES);
		send_request(ACT_APPEND,    7'd0,   32'd1);
		send_request(ACT_OVERWRITE, 7'd2,   32'h8000_0000);
		send_request(ACT_INSERT,    7'd0,   32'h1234_5678);
		send_request(ACT_INSERT,    7'd2,   32'hA5A5_A5A5);
		send_request(ACT_INSERT,    7'd5,   32'd7);
		send_request(ACT_OVERWRITE, 7'd1,   32'h5A5A_5A5A);
		send_request(ACT_OVERWRITE, 7'd64,  32'd9);
		send_request(ACT_OVERWRITE, 7'd2,   32'd0);
		send_request(ACT_READ,      7'd127, 32'd0);
		send_request(ACT_READ,      7'd3,   32'd0);
		send_request(ACT_SEARCH,    7'd0,   32'd1);
		send_request(ACT_SEARCH,    7'd0,   32'd2);
		send_request(ACT_REMOVE,    7'd0,   ALL_ONES);
		send_request(ACT_REMOVE,    7'd4,   32'd0);
		send_request(ACT_UNDEFINED, 7'd127, ALL_ONES);
		send_request(ACT_INSERT,    7'd64,  32'd3);
		send_request(ACT_CLEAR,     7'd127, ALL_ONES);
		send_request(ACT_READ,      7'd0,   32'd0);

		// Random traffic under each idling mix.
		send_random(400);
		send_idle_pct  = 66;
		send_random(400);
		send_idle_pct  = 0;
		recv_stall_pct = 66;
		send_random(400);
		send_idle_pct  = 35;
		recv_stall_pct = 35;
		send_random(400);

		// Long receiver hold-off while the list is filled past capacity.
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		holdoff_pending = 1'b1;
		repeat (70)
			send_request(ACT_APPEND, 7'($urandom_range(0, 127)),
				$urandom_range(1, ALL_ONES));
		mode      = MODE_GROW;
		mode_left = 40;
		send_random(130);

		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> files.f
rtl/core/ils_pkg.sv
rtl/core/ils_mem.sv
rtl/core/ils_ctrl.sv
rtl/core/indexed_list_store_top.sv
tb/sv/list_scoreboard_pkg.sv
tb/sv/indexed_list_store_top_test.sv
